// ----- hdl/lfucd_pkg.sv -----
package lfucd_pkg;

    // fixed field widths of the request and response channels
    localparam int KEY_W       = 16;
    localparam int SIZE_W      = 32;
    localparam int IDX_OUT_W   = 2;
    localparam int COUNT_OUT_W = 16;

    // request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // control part of the token that travels down the cell chain
    typedef struct packed {
        logic valid;
        logic req_type;
        logic found;
    } t_tok_ctl;

endpackage

// ----- hdl/lfucd_req_if.sv -----
interface lfucd_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [lfucd_pkg::KEY_W-1:0]      key;
    logic [lfucd_pkg::SIZE_W-1:0]     item_size;

    modport source (output valid, req_type, key, item_size, input ready);
    modport sink   (input valid, req_type, key, item_size, output ready);
endinterface

// ----- hdl/lfucd_rsp_if.sv -----
interface lfucd_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [lfucd_pkg::IDX_OUT_W-1:0]     entry_index;
    logic [lfucd_pkg::SIZE_W-1:0]        stored_size;
    logic [lfucd_pkg::COUNT_OUT_W-1:0]   use_count;

    modport source (output valid, hit, entry_index, stored_size, use_count, input ready);
    modport sink   (input valid, hit, entry_index, stored_size, use_count, output ready);
endinterface

// ----- hdl/lfucd_cell.sv -----
module lfucd_cell #(
    parameter int IDX_W      = 2,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16,
    parameter int CELL_IDX   = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // token from the previous cell
    input  lfucd_pkg::t_tok_ctl           i_ctl,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [lfucd_pkg::SIZE_W-1:0]  i_size,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic [COUNT_BITS-1:0]         i_cnt,
    input  logic [lfucd_pkg::SIZE_W-1:0]  i_rsize,
    // token to the next cell
    output lfucd_pkg::t_tok_ctl           o_ctl,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [lfucd_pkg::SIZE_W-1:0]  o_size,
    output logic [IDX_W-1:0]              o_idx,
    output logic [COUNT_BITS-1:0]         o_cnt,
    output logic [lfucd_pkg::SIZE_W-1:0]  o_rsize,
    // insert write-back, broadcast to all cells
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  logic [KEY_BITS-1:0]           i_wr_key,
    input  logic [lfucd_pkg::SIZE_W-1:0]  i_wr_size
);

    localparam logic [IDX_W-1:0]      MY_IDX    = IDX_W'(CELL_IDX);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // entry state
    logic                         r_valid;
    logic [KEY_BITS-1:0]          r_key;
    logic [lfucd_pkg::SIZE_W-1:0] r_size;
    logic [COUNT_BITS-1:0]        r_cnt;

    // token registers
    lfucd_pkg::t_tok_ctl          r_ctl, n_ctl;
    logic [KEY_BITS-1:0]          r_tkey;
    logic [lfucd_pkg::SIZE_W-1:0] r_tsize;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [COUNT_BITS-1:0]        r_tcnt, n_cnt;
    logic [lfucd_pkg::SIZE_W-1:0] r_rsize, n_rsize;

    logic                         hit_here;
    logic                         take_here;
    logic                         wr_here;
    logic [COUNT_BITS-1:0]        cnt_inc;

    // saturating increment of the hit counter
    assign cnt_inc = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + COUNT_BITS'(1);
    assign wr_here = i_wr_en && (i_wr_idx == MY_IDX);

    // match on lookup, running minimum on insert
    always_comb begin
        hit_here  = 1'b0;
        take_here = 1'b0;
        if (i_ctl.valid) begin
            if (i_ctl.req_type == lfucd_pkg::REQ_LOOKUP) begin
                hit_here = !i_ctl.found && r_valid && (r_key == i_key);
            end else begin
                take_here = !i_ctl.found || (r_cnt < i_cnt);
            end
        end
        n_ctl   = i_ctl;
        n_idx   = i_idx;
        n_cnt   = i_cnt;
        n_rsize = i_rsize;
        if (hit_here) begin
            n_ctl.found = 1'b1;
            n_idx       = MY_IDX;
            n_cnt       = cnt_inc;
            n_rsize     = r_size;
        end else if (take_here) begin
            n_ctl.found = 1'b1;
            n_idx       = MY_IDX;
            n_cnt       = r_cnt;
        end
    end

    // control state: valid mark, counter, token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (wr_here) begin
                r_valid <= 1'b1;
                r_cnt   <= COUNT_BITS'(1);
            end else if (hit_here) begin
                r_cnt <= cnt_inc;
            end
        end
    end

    // payload: entry tag and size, token data
    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_key  <= i_wr_key;
            r_size <= i_wr_size;
        end
        r_tkey  <= i_key;
        r_tsize <= i_size;
        r_idx   <= n_idx;
        r_tcnt  <= n_cnt;
        r_rsize <= n_rsize;
    end

    assign o_ctl   = r_ctl;
    assign o_key   = r_tkey;
    assign o_size  = r_tsize;
    assign o_idx   = r_idx;
    assign o_cnt   = r_tcnt;
    assign o_rsize = r_rsize;

endmodule

// ----- hdl/lfu_cache_directory_core.sv -----
// LFU cache directory: a small fully associative table of ENTRIES entries,
// each holding a valid mark, a key tag, a size and a hit counter.
// i_req (sink) carries one request per transaction: req_type selects lookup
// or insert, key is the tag, item_size is written on insert.
// o_rsp (source) returns exactly one response per request: hit flag, entry
// index, stored size and use count.
// Each entry lives in one cell of a chain; a request walks the chain one
// cell per cycle, doing the lookup match and the least-count search as it
// goes. An insert writes its victim as the token leaves the chain. The
// result is registered in a pending register, then loaded into the output
// register. One request is in flight at a time; the next request is taken
// the cycle after the previous response is loaded into the output register.
// Reset clears all valid marks and counters and empties the pipeline.
// If the receiver stalls, the response holds in the output register, one
// more finished response waits behind it, and i_req.ready stays low.
module lfu_cache_directory_core #(
    parameter int ENTRIES    = 3,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lfucd_req_if.sink        i_req,
    lfucd_rsp_if.source      o_rsp
);

    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int SIZE_W      = lfucd_pkg::SIZE_W;
    localparam int IDX_OUT_W   = lfucd_pkg::IDX_OUT_W;
    localparam int COUNT_OUT_W = lfucd_pkg::COUNT_OUT_W;

    // token chain wires, stage 0 is the injection point
    lfucd_pkg::t_tok_ctl   c_ctl   [ENTRIES+1];
    logic [KEY_BITS-1:0]   c_key   [ENTRIES+1];
    logic [SIZE_W-1:0]     c_size  [ENTRIES+1];
    logic [IDX_W-1:0]      c_idx   [ENTRIES+1];
    logic [COUNT_BITS-1:0] c_cnt   [ENTRIES+1];
    logic [SIZE_W-1:0]     c_rsize [ENTRIES+1];

    logic                  r_busy;
    logic                  req_fire;
    logic                  wr_en;
    logic                  end_hit;
    logic                  load_out;

    // finished result waiting for the output register
    logic                   r_pend_v;
    logic                   r_pend_hit;
    logic [IDX_OUT_W-1:0]   r_pend_idx;
    logic [SIZE_W-1:0]      r_pend_size;
    logic [COUNT_OUT_W-1:0] r_pend_cnt;

    // output register
    logic                   r_out_v;
    logic                   r_out_hit;
    logic [IDX_OUT_W-1:0]   r_out_idx;
    logic [SIZE_W-1:0]      r_out_size;
    logic [COUNT_OUT_W-1:0] r_out_cnt;

    assign i_req.ready = !r_busy;
    assign req_fire    = i_req.valid && !r_busy;

    // inject a new token
    always_comb begin
        c_ctl[0].valid    = req_fire;
        c_ctl[0].req_type = i_req.req_type;
        c_ctl[0].found    = 1'b0;
    end
    assign c_key[0]   = KEY_BITS'(i_req.key);
    assign c_size[0]  = i_req.item_size;
    assign c_idx[0]   = '0;
    assign c_cnt[0]   = '0;
    assign c_rsize[0] = '0;

    // write-back of the insert victim as the token leaves the chain
    assign wr_en = c_ctl[ENTRIES].valid && (c_ctl[ENTRIES].req_type == lfucd_pkg::REQ_INSERT);

    // chain of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfucd_cell #(
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (c_ctl[g]),
            .i_key     (c_key[g]),
            .i_size    (c_size[g]),
            .i_idx     (c_idx[g]),
            .i_cnt     (c_cnt[g]),
            .i_rsize   (c_rsize[g]),
            .o_ctl     (c_ctl[g+1]),
            .o_key     (c_key[g+1]),
            .o_size    (c_size[g+1]),
            .o_idx     (c_idx[g+1]),
            .o_cnt     (c_cnt[g+1]),
            .o_rsize   (c_rsize[g+1]),
            .i_wr_en   (wr_en),
            .i_wr_idx  (c_idx[ENTRIES]),
            .i_wr_key  (c_key[ENTRIES]),
            .i_wr_size (c_size[ENTRIES])
        );
    end

    assign end_hit  = (c_ctl[ENTRIES].req_type == lfucd_pkg::REQ_LOOKUP)
                      && c_ctl[ENTRIES].found;
    assign load_out = r_pend_v && (!r_out_v || o_rsp.ready);

    // control: busy flag, pending and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (req_fire) begin
                r_busy <= 1'b1;
            end else if (load_out) begin
                r_busy <= 1'b0;
            end
            if (c_ctl[ENTRIES].valid) begin
                r_pend_v <= 1'b1;
            end else if (load_out) begin
                r_pend_v <= 1'b0;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // result formation at the end of the chain
    always_ff @(posedge i_clk) begin
        if (c_ctl[ENTRIES].valid) begin
            if (c_ctl[ENTRIES].req_type == lfucd_pkg::REQ_INSERT) begin
                r_pend_hit  <= 1'b0;
                r_pend_idx  <= IDX_OUT_W'(c_idx[ENTRIES]);
                r_pend_size <= c_size[ENTRIES];
                r_pend_cnt  <= COUNT_OUT_W'(1);
            end else if (end_hit) begin
                r_pend_hit  <= 1'b1;
                r_pend_idx  <= IDX_OUT_W'(c_idx[ENTRIES]);
                r_pend_size <= c_rsize[ENTRIES];
                r_pend_cnt  <= COUNT_OUT_W'(c_cnt[ENTRIES]);
            end else begin
                r_pend_hit  <= 1'b0;
                r_pend_idx  <= '0;
                r_pend_size <= '0;
                r_pend_cnt  <= '0;
            end
        end
        if (load_out) begin
            r_out_hit  <= r_pend_hit;
            r_out_idx  <= r_pend_idx;
            r_out_size <= r_pend_size;
            r_out_cnt  <= r_pend_cnt;
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.stored_size = r_out_size;
    assign o_rsp.use_count   = r_out_cnt;

endmodule

// ----- tb/sv/lfu_dir_checker.sv -----
`timescale 1ns / 100ps

module lfu_dir_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lfucd_req_if  i_req,
    lfucd_rsp_if  i_rsp,
    output int    o_err_count,
    output int    o_pending
);

    localparam int KEY_W       = lfucd_pkg::KEY_W;
    localparam int SIZE_W      = lfucd_pkg::SIZE_W;
    localparam int IDX_OUT_W   = lfucd_pkg::IDX_OUT_W;
    localparam int COUNT_OUT_W = lfucd_pkg::COUNT_OUT_W;

    localparam int                   NUM_ENTRIES = 3;
    localparam logic [COUNT_OUT_W-1:0] USE_MAX   = '1;

    typedef struct packed {
        logic                   hit;
        logic [IDX_OUT_W-1:0]   idx;
        logic [SIZE_W-1:0]      size;
        logic [COUNT_OUT_W-1:0] count;
    } t_dir_rsp;

    // shadow copy of the directory contents
    logic                   tag_valid [NUM_ENTRIES];
    logic [KEY_W-1:0]       tag_key   [NUM_ENTRIES];
    logic [SIZE_W-1:0]      tag_size  [NUM_ENTRIES];
    logic [COUNT_OUT_W-1:0] use_cnt   [NUM_ENTRIES];

    t_dir_rsp pending_rsps[$];
    t_dir_rsp want;

    // apply one request to the shadow directory, return the response it gives
    function automatic t_dir_rsp lookup_or_replace(logic req_type, logic [KEY_W-1:0] key,
                                                   logic [SIZE_W-1:0] size);
        t_dir_rsp r;
        logic     found;
        int       victim;
        r      = '0;
        found  = 1'b0;
        victim = 0;
        if (req_type == lfucd_pkg::REQ_LOOKUP) begin
            // lowest-index valid match wins; a miss leaves everything alone
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (!found && tag_valid[i] && tag_key[i] == key) begin
                    found = 1'b1;
                    if (use_cnt[i] != USE_MAX)
                        use_cnt[i] = use_cnt[i] + COUNT_OUT_W'(1);
                    r.hit   = 1'b1;
                    r.idx   = i[IDX_OUT_W-1:0];
                    r.size  = tag_size[i];
                    r.count = use_cnt[i];
                end
            end
        end else begin
            // least count, lowest index on ties, invalid entries included
            for (int i = 1; i < NUM_ENTRIES; i++) begin
                if (use_cnt[i] < use_cnt[victim])
                    victim = i;
            end
            tag_valid[victim] = 1'b1;
            tag_key[victim]   = key;
            tag_size[victim]  = size;
            use_cnt[victim]   = COUNT_OUT_W'(1);
            r.idx   = victim[IDX_OUT_W-1:0];
            r.size  = size;
            r.count = COUNT_OUT_W'(1);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [SIZE_W-1:0] exp_val,
                               logic [SIZE_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            o_err_count++;
        end
    endtask

    // monitor both channels: check responses first, then predict new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                tag_valid[i] = 1'b0;
                tag_key[i]   = '0;
                tag_size[i]  = '0;
                use_cnt[i]   = '0;
            end
            pending_rsps.delete();
            o_err_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_rsps.size() == 0) begin
                    $display("%0t: unexpected response transaction: expected none, actual %0h",
                             $time, {i_rsp.hit, i_rsp.entry_index, i_rsp.stored_size,
                                     i_rsp.use_count});
                    o_err_count++;
                end else begin
                    want = pending_rsps.pop_front();
                    check_field("hit", SIZE_W'(want.hit), SIZE_W'(i_rsp.hit));
                    check_field("entry_index", SIZE_W'(want.idx),
                                SIZE_W'(i_rsp.entry_index));
                    check_field("stored_size", want.size, i_rsp.stored_size);
                    check_field("use_count", SIZE_W'(want.count),
                                SIZE_W'(i_rsp.use_count));
                end
            end
            if (i_req.valid && i_req.ready)
                pending_rsps.push_back(lookup_or_replace(i_req.req_type, i_req.key,
                                                         i_req.item_size));
        end
        o_pending = pending_rsps.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int KEY_W  = lfucd_pkg::KEY_W;
    localparam int SIZE_W = lfucd_pkg::SIZE_W;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int HIT_LOOKUPS  = 30;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   pending;
    int   cycle_cnt;
    bit   send_gaps_on;
    bit   rsp_stalls_on;

    lfucd_req_if req_ch ();
    lfucd_rsp_if rsp_ch ();

    lfu_cache_directory_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lfu_dir_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // timeout watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // response side: random stall bursts while enabled
    always begin
        @(posedge i_clk);
        if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        rsp_ch.ready <= 1'b1;
    end

    // one request transaction, then maybe an idle burst
    task automatic issue_request(logic req_type, logic [KEY_W-1:0] key,
                                 logic [SIZE_W-1:0] size);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= req_type;
        req_ch.key       <= key;
        req_ch.item_size <= size;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    logic [KEY_W-1:0] key_pool [6];
    logic [KEY_W-1:0] key;
    logic             req_type;

    initial begin
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= lfucd_pkg::REQ_LOOKUP;
        req_ch.key       <= '0;
        req_ch.item_size <= '0;
        rsp_ch.ready     <= 1'b0;
        i_rst_n          <= 1'b0;
        send_gaps_on     = 1'b0;
        rsp_stalls_on    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty directory, fill-up order, hits, ties, duplicates
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h0000, 32'h0000_0000);  // invalid entries must not hit
        issue_request(lfucd_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(lfucd_pkg::REQ_INSERT, 16'h1234, 32'hA5A5_5A5A);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'hFFFF, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h1234, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h1234, 32'h0000_0000);
        // tie on count, duplicate key
        issue_request(lfucd_pkg::REQ_INSERT, 16'h1234, 32'h5A5A_A5A5);
        // lowest matching index wins
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h1234, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h7777, 32'h1234_5678);  // miss
        issue_request(lfucd_pkg::REQ_INSERT, 16'h8000, 32'h8000_0001);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'h8000, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'hFFFF, 32'h0000_0000);
        issue_request(lfucd_pkg::REQ_INSERT, 16'h5555, 32'h0000_0001);
        issue_request(lfucd_pkg::REQ_LOOKUP, 16'hAAAA, 32'h0000_0000);
        drain_responses();

        // repeated hits on one key, back to back
        issue_request(lfucd_pkg::REQ_INSERT, 16'hBEEF, 32'h1234_5678);
        repeat (HIT_LOOKUPS) issue_request(lfucd_pkg::REQ_LOOKUP, 16'hBEEF, $urandom);
        drain_responses();

        // random traffic over a small key pool so hits and evictions are common
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        send_gaps_on  = 1'b1;
        rsp_stalls_on = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_responses();
            end
            if (n == RANDOM_ITEMS - 150) begin
                send_gaps_on  = 1'b0;
                rsp_stalls_on = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                key_pool[$urandom_range(0, 5)] = KEY_W'($urandom);
            req_type = ($urandom_range(0, 9) < 3) ? lfucd_pkg::REQ_INSERT
                                                  : lfucd_pkg::REQ_LOOKUP;
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                              : key_pool[$urandom_range(0, 5)];
            issue_request(req_type, key, $urandom);
        end

        // wind down and give the verdict
        drain_responses();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
